>>> rtl/core/psrb_pkg.sv
// Package for the per-source reorder buffer.
// Holds the request and result structs, status codes and controller states.
// No dependencies.
package psrb_pkg;

    // Status codes carried on each result
    localparam logic [1:0] STATUS_RELEASED = 2'd0;
    localparam logic [1:0] STATUS_HELD     = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

    // One arriving message
    typedef struct packed {
        logic [3:0]  source_id;
        logic [15:0] seq_tag;
        logic [31:0] payload_handle;
    } in_req_t;

    // One result
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_source;
        logic [15:0] out_tag;
        logic [31:0] out_payload;
        logic        last;
    } out_res_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DRAIN
    } psrb_state_t;

endpackage

>>> rtl/core/psrb_row_mem.sv
// Per-source row store: expected tag, window head and held mask.
// Synchronous memory with a registered read; rows read as zero until written.
// Depends on nothing.
module psrb_row_mem #(
    parameter int SOURCES = 16,
    parameter int SRC_W   = 4,
    parameter int ROW_W   = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [SRC_W-1:0] rd_addr,
    output logic [ROW_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [SRC_W-1:0] wr_addr,
    input  logic [ROW_W-1:0] wr_data
);

    logic [ROW_W-1:0] mem [SOURCES];
    logic             written_reg [SOURCES];
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_written_reg;

    // Write the row storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Mark rows as written; reset clears every mark at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SOURCES; i++)
            begin
                written_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // Register the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_written_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Unwritten rows read as their reset value
    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

>>> rtl/core/psrb_pay_mem.sv
// Held payload store, one entry per source and window slot.
// Synchronous memory with a registered read; contents undefined until written.
// Depends on nothing.
module psrb_pay_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write and read the payload storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/per_source_reorder_buffer.sv
// Per-source sequence reorder buffer: top level with the controller.
// Depends on psrb_pkg, psrb_row_mem and psrb_pay_mem.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   It carries a source, a sequence tag and a payload handle. Results leave on
//   result, each valid for exactly one cycle while strobe is high; the
//   receiver cannot stall, so every strobe must be taken.
//   A request whose tag equals the source's expected tag is released, then
//   every held request that follows it in sequence, one result per cycle.
//   A tag ahead by 1 to WINDOW-1 is held (status held); anything else, and an
//   unknown source, is rejected. The last result of each run has last set.
// Timing:
//   The first result is registered: the request passes the lookup state,
//   where its source row read returns, and then the result register.
//   Busy stays high through the lookup and the drain, so a new request is
//   not taken before the previous one is finished. The pace is set by the
//   row read-modify-write and by the single read port of the payload
//   memory, which gives one drained entry per cycle.
// Reset:
//   rst_n clears the controller and marks every row as unwritten, so all
//   expected tags read as zero and no entry is held. No clearing pass is needed.
module per_source_reorder_buffer #(
    parameter int SOURCES      = 16,
    parameter int WINDOW       = 16,
    parameter int TAG_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  psrb_pkg::in_req_t request,
    output logic              strobe,
    output psrb_pkg::out_res_t result
);

    import psrb_pkg::*;

    localparam int SRC_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int HW    = $clog2(WINDOW);
    localparam int ROW_W = TAG_BITS + HW + WINDOW;
    localparam int DEPTH = SOURCES * WINDOW;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = TAG_BITS + 8;

    psrb_state_t         state_reg, state_next;
    logic [3:0]          src_reg, src_next;
    logic                src_ok_reg, src_ok_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [HW-1:0]       head_reg, head_next;
    logic [WINDOW-1:0]   mask_reg, mask_next;
    logic                strobe_reg, strobe_next;
    out_res_t            result_reg, result_next;

    logic                row_rd_en;
    logic [ROW_W-1:0]    row_rd_data;
    logic                row_wr_en;
    logic [ROW_W-1:0]    row_wr_data;
    logic [SRC_W-1:0]    src_idx;

    logic                pay_rd_en;
    logic [PW-1:0]       pay_rd_addr;
    logic [PAYLOAD_BITS-1:0] pay_rd_data;
    logic                pay_wr_en;
    logic [PW-1:0]       pay_wr_addr;
    logic [PW-1:0]       base_addr;

    logic [TAG_BITS-1:0] exp_tag;
    logic [HW-1:0]       row_head;
    logic [WINDOW-1:0]   row_mask;
    logic [TAG_BITS-1:0] tag_gap;
    logic                far;
    logic [HW-1:0]       gap_slot;

    // Add two slot offsets modulo the window
    function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] a,
                                               input logic [HW-1:0] b);
        logic [HW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (HW + 1)'(WINDOW))
        begin
            s = s - (HW + 1)'(WINDOW);
        end
        return s[HW-1:0];
    endfunction

    psrb_row_mem #(
        .SOURCES (SOURCES),
        .SRC_W   (SRC_W),
        .ROW_W   (ROW_W)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (row_rd_en),
        .rd_addr (SRC_W'(request.source_id)),
        .rd_data (row_rd_data),
        .wr_en   (row_wr_en),
        .wr_addr (src_idx),
        .wr_data (row_wr_data)
    );

    psrb_pay_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (PW),
        .DATA_W (PAYLOAD_BITS)
    ) u_pay_mem (
        .clk     (clk),
        .rd_en   (pay_rd_en),
        .rd_addr (pay_rd_addr),
        .rd_data (pay_rd_data),
        .wr_en   (pay_wr_en),
        .wr_addr (pay_wr_addr),
        .wr_data (pay_reg)
    );

    // Unpack the row and measure the tag distance
    assign exp_tag   = row_rd_data[ROW_W-1 -: TAG_BITS];
    assign row_head  = row_rd_data[WINDOW +: HW];
    assign row_mask  = row_rd_data[WINDOW-1:0];
    assign tag_gap   = tag_reg - exp_tag;
    assign far       = CW'(tag_gap) >= CW'(WINDOW);
    assign gap_slot  = HW'(tag_gap);
    assign src_idx   = SRC_W'(src_reg);
    assign base_addr = PW'(src_idx) * PW'(WINDOW);

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Hold the controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Hold the working copy of the request and the result register
    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        src_ok_reg <= src_ok_next;
        tag_reg    <= tag_next;
        pay_reg    <= pay_next;
        head_reg   <= head_next;
        mask_reg   <= mask_next;
        result_reg <= result_next;
    end

    // Next state, memory accesses and results
    always_comb
    begin
        state_next  = state_reg;
        src_next    = src_reg;
        src_ok_next = src_ok_reg;
        tag_next    = tag_reg;
        pay_next    = pay_reg;
        head_next   = head_reg;
        mask_next   = mask_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        row_rd_en   = 1'b0;
        row_wr_en   = 1'b0;
        row_wr_data = {exp_tag, row_head, row_mask};
        pay_rd_en   = 1'b0;
        pay_rd_addr = base_addr;
        pay_wr_en   = 1'b0;
        pay_wr_addr = base_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take a request and fetch its source row
                if (start)
                begin
                    row_rd_en   = 1'b1;
                    src_next    = request.source_id;
                    src_ok_next = 32'(request.source_id) < 32'(SOURCES);
                    tag_next    = TAG_BITS'(request.seq_tag);
                    pay_next    = PAYLOAD_BITS'(request.payload_handle);
                    state_next  = ST_LOOK;
                end
            end

            ST_LOOK:
            begin
                strobe_next            = 1'b1;
                result_next.out_source = src_reg;
                result_next.out_tag    = 16'(tag_reg);
                result_next.out_payload = '0;
                result_next.last       = 1'b1;
                state_next             = ST_IDLE;
                if (!src_ok_reg || (tag_gap != '0 && far))
                begin
                    // Drop: unknown source or outside the window
                    result_next.status = STATUS_REJECTED;
                end
                else if (tag_gap != '0)
                begin
                    // Hold the payload in its slot
                    result_next.status = STATUS_HELD;
                    pay_wr_en   = 1'b1;
                    pay_wr_addr = base_addr + PW'(wrap_add(row_head, gap_slot));
                    row_wr_en   = 1'b1;
                    row_wr_data = {exp_tag, row_head,
                                   row_mask | (WINDOW'(1) << gap_slot)};
                end
                else
                begin
                    // Release in order and advance past it
                    result_next.status      = STATUS_RELEASED;
                    result_next.out_payload = 32'(pay_reg);
                    result_next.last        = !row_mask[1];
                    tag_next  = exp_tag + TAG_BITS'(1);
                    head_next = wrap_add(row_head, HW'(1));
                    mask_next = row_mask >> 1;
                    if (row_mask[1])
                    begin
                        pay_rd_en   = 1'b1;
                        pay_rd_addr = base_addr + PW'(wrap_add(row_head, HW'(1)));
                        state_next  = ST_DRAIN;
                    end
                    else
                    begin
                        row_wr_en   = 1'b1;
                        row_wr_data = {exp_tag + TAG_BITS'(1),
                                       wrap_add(row_head, HW'(1)), row_mask >> 1};
                    end
                end
            end

            ST_DRAIN:
            begin
                // Release one held entry per cycle
                strobe_next             = 1'b1;
                result_next.status      = STATUS_RELEASED;
                result_next.out_source  = src_reg;
                result_next.out_tag     = 16'(tag_reg);
                result_next.out_payload = 32'(pay_rd_data);
                result_next.last        = !mask_reg[1];
                tag_next  = tag_reg + TAG_BITS'(1);
                head_next = wrap_add(head_reg, HW'(1));
                mask_next = mask_reg >> 1;
                if (mask_reg[1])
                begin
                    pay_rd_en   = 1'b1;
                    pay_rd_addr = base_addr + PW'(wrap_add(head_reg, HW'(1)));
                end
                else
                begin
                    row_wr_en   = 1'b1;
                    row_wr_data = {tag_reg + TAG_BITS'(1),
                                   wrap_add(head_reg, HW'(1)), mask_reg >> 1};
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result only follows a lookup or a drain step
    a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg != ST_IDLE))
        else $error("result strobe without preceding work");

    // A lookup only follows an accepted request
    a_look_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> $past(start && !busy))
        else $error("lookup without an accepted request");

    // Drained results are always releases
    a_drain_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && $past(state_reg == ST_DRAIN)) |-> (result.status == STATUS_RELEASED))
        else $error("drain produced a non-release result");

    // Holds and rejects are single results with no payload
    a_report_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.status != STATUS_RELEASED) |->
            (result.last && result.out_payload == '0))
        else $error("hold or reject result malformed");

endmodule

>>> test/tb.sv
// Testbench for per_source_reorder_buffer: directed, tag-wrap and random tests
// checked against a cycle-free predictor of the per-source reorder behaviour.
// Depends on psrb_pkg and the per_source_reorder_buffer RTL.
module tb;
    import psrb_pkg::*;

    localparam int NUM_SOURCES    = 16;
    localparam int WIN            = 16;
    localparam int RANDOM_ITEMS   = 175;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 30;
    localparam int SETTLE_CYCLES  = 40;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    in_req_t  request;
    logic     strobe;
    out_res_t result;

    // Predictor state: next tag per source and the held slots
    logic [15:0] next_tag  [NUM_SOURCES];
    logic        slot_full [NUM_SOURCES][WIN];
    logic [31:0] slot_pay  [NUM_SOURCES][WIN];

    out_res_t awaited_results [$];
    out_res_t want;
    int       errors = 0;
    int       idle_cycles;
    int       burst_left;
    logic     pace_sender;

    per_source_reorder_buffer #(
        .SOURCES      (NUM_SOURCES),
        .WINDOW       (WIN),
        .TAG_BITS     (16),
        .PAYLOAD_BITS (32)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clear the predictor to its post-reset state
    task automatic model_reset();
        int s, d;
        for (s = 0; s < NUM_SOURCES; s++)
        begin
            next_tag[s] = '0;
            for (d = 0; d < WIN; d++)
            begin
                slot_full[s][d] = 1'b0;
                slot_pay[s][d]  = '0;
            end
        end
    endtask

    // Predict the results of one accepted request and queue them
    task automatic model_arrival(input in_req_t msg);
        out_res_t    res;
        logic [15:0] tag_gap;
        int          src, run, k, i;
        src             = int'(msg.source_id);
        res.out_source  = msg.source_id;
        res.out_tag     = msg.seq_tag;
        res.out_payload = '0;
        res.last        = 1'b1;
        if (src >= NUM_SOURCES)
        begin
            res.status = STATUS_REJECTED;
            awaited_results.push_back(res);
            return;
        end
        tag_gap = msg.seq_tag - next_tag[src];
        // Hold a tag inside the window, reject anything further off
        if (tag_gap != 0)
        begin
            if (tag_gap < WIN)
            begin
                res.status              = STATUS_HELD;
                slot_full[src][tag_gap] = 1'b1;
                slot_pay[src][tag_gap]  = msg.payload_handle;
            end
            else
                res.status = STATUS_REJECTED;
            awaited_results.push_back(res);
            return;
        end
        // Release in order, then drain the held run behind it
        run = 1;
        while (run < WIN && slot_full[src][run])
            run++;
        res.status      = STATUS_RELEASED;
        res.out_payload = msg.payload_handle;
        res.last        = (run == 1);
        awaited_results.push_back(res);
        for (k = 1; k < run; k++)
        begin
            res.out_tag     = msg.seq_tag + 16'(k);
            res.out_payload = slot_pay[src][k];
            res.last        = (k == run - 1);
            awaited_results.push_back(res);
        end
        // Shift the slots down past the drained run
        for (i = 1; i < WIN; i++)
        begin
            if (i + run < WIN)
            begin
                slot_full[src][i] = slot_full[src][i + run];
                slot_pay[src][i]  = slot_pay[src][i + run];
            end
            else
            begin
                slot_full[src][i] = 1'b0;
                slot_pay[src][i]  = '0;
            end
        end
        next_tag[src] = next_tag[src] + 16'(run);
    endtask

    // Send one request, pacing in bursts when pace_sender is set, and predict it once accepted
    task automatic send_msg(input logic [3:0] src, input logic [15:0] tag,
                            input logic [31:0] pay);
        in_req_t msg;
        int      gap;
        msg.source_id      = src;
        msg.seq_tag        = tag;
        msg.payload_handle = pay;
        if (pace_sender && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            if (start)
                start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        start   <= 1'b1;
        request <= msg;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        model_arrival(msg);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Hold the sender off until every predicted result has arrived
    task automatic wait_drained();
        if (start)
            start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            if (errors < REPORT_LIMIT)
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            errors++;
        end
    endtask

    // In-order release, far and behind rejects, holds, duplicate hold, drain
    task automatic test_in_order_and_reject();
        logic [15:0] t0;
        pace_sender = 1'b1;
        t0 = next_tag[0];
        send_msg(4'd0, t0, 32'h0000_0000);
        send_msg(4'd0, t0 + 16'd1, 32'hFFFF_FFFF);
        send_msg(4'd0, t0 + 16'd1, 32'h1234_5678);
        send_msg(4'd0, t0 + 16'd2 + 16'(WIN), 32'hDEAD_BEEF);
        send_msg(4'd0, t0 + 16'd2 + 16'(WIN) - 16'd1, 32'hA5A5_5A5A);
        send_msg(4'd0, t0 + 16'd3, 32'h0F0F_0F0F);
        send_msg(4'd0, t0 + 16'd3, 32'hF0F0_F0F0);
        send_msg(4'd0, 16'hFFFF, 32'h8000_0001);
        send_msg(4'd0, t0 + 16'd2, 32'h7FFF_FFFE);
        wait_drained();
    endtask

    // Fill every slot of the top source, then release the full run
    task automatic test_full_held_run();
        logic [15:0] base;
        int          d;
        pace_sender = 1'b1;
        base = next_tag[15];
        for (d = WIN - 1; d >= 1; d--)
            send_msg(4'd15, base + 16'(d), $urandom());
        send_msg(4'd15, base, $urandom());
        wait_drained();
    endtask

    // Tag distances that wrap modulo the tag width, on one source
    task automatic test_tag_wrap();
        logic [15:0] base;
        pace_sender = 1'b0;
        base = next_tag[7];
        send_msg(4'd7, base - 16'd1, $urandom());
        send_msg(4'd7, base - 16'(WIN), $urandom());
        send_msg(4'd7, base + 16'h8000, $urandom());
        send_msg(4'd7, base + 16'(WIN) - 16'd1, $urandom());
        send_msg(4'd7, base + 16'(WIN), $urandom());
        send_msg(4'd7, base + 16'd1, $urandom());
        send_msg(4'd7, base, $urandom());
        wait_drained();
    endtask

    // Mostly shuffled in-window runs, plus broken runs and noise
    task automatic test_random_traffic();
        logic [15:0] order [$];
        logic [15:0] base, swap_tag, tag;
        int          sent, pick, src, len, offset, j, k;
        sent        = 0;
        pace_sender = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            src  = $urandom_range(0, NUM_SOURCES - 1);
            base = next_tag[src];
            if (pick <= 6)
            begin
                // a broken run leaves out the opening tag so its entries stay held
                offset = (pick == 6) ? 1 : 0;
                len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4)
                                                  : $urandom_range(1, WIN - offset);
                order.delete();
                for (j = 0; j < len; j++)
                    order.push_back(base + 16'(offset + j));
                for (j = len - 1; j > 0; j--)
                begin
                    k        = $urandom_range(0, j);
                    swap_tag = order[j];
                    order[j] = order[k];
                    order[k] = swap_tag;
                end
                for (j = 0; j < len; j++)
                begin
                    send_msg(4'(src), order[j], $urandom());
                    sent++;
                end
            end
            else
            begin
                case (pick)
                    7:       tag = 16'($urandom_range(0, 16'hFFFF));
                    8:       tag = ($urandom_range(0, 1) != 0)
                                   ? base - 16'($urandom_range(1, 4))
                                   : base + 16'(WIN) + 16'($urandom_range(0, 3));
                    default: tag = base + 16'($urandom_range(1, WIN - 1));
                endcase
                send_msg(4'(src), tag, $urandom());
                sent++;
            end
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (strobe === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $error("result with no request pending: %p", result);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(result.status));
                    check_field("out_source", 32'(want.out_source),
                                32'(result.out_source));
                    check_field("out_tag", 32'(want.out_tag), 32'(result.out_tag));
                    check_field("out_payload", want.out_payload, result.out_payload);
                    check_field("last", 32'(want.last), 32'(result.last));
                end
            end
            else if (strobe !== 1'b0)
            begin
                if (errors < REPORT_LIMIT)
                    $error("strobe unknown: %b", strobe);
                errors++;
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            idle_cycles <= 0;
        else
        begin
            if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Reset once, run the tests in turn, then report
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        burst_left  = 0;
        pace_sender = 1'b1;
        model_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_in_order_and_reject();
        test_full_held_run();
        test_tag_wrap();
        test_random_traffic();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            $error("%0d predicted results never arrived", awaited_results.size());
        if (errors == 0 && awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/psrb_pkg.sv
rtl/core/psrb_row_mem.sv
rtl/core/psrb_pay_mem.sv
rtl/core/per_source_reorder_buffer.sv
test/tb.sv
